// ===== design/bloom_filter_int64_keys_core_macros.svh =====
// Assertion helpers for the bloom filter core.
`ifndef BLOOM_FILTER_INT64_KEYS_CORE_MACROS_SVH
`define BLOOM_FILTER_INT64_KEYS_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define BFK_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("bfk check failed");

// Next-cycle implication, disabled in reset.
`define BFK_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("bfk check failed");

`endif

// ===== design/bfk_pkg.sv =====
package bfk_pkg;

	localparam int DEF_MAX_FILTER_BITS = 65536;
	localparam int DEF_MAX_HASHES      = 16;

	localparam int FILTER_BITS_W = 17;
	localparam int NUM_HASHES_W  = 5;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 17;

	localparam logic [CFG_INDEX_W-1:0] REG_FILTER_BITS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_NUM_HASHES  = 2'd1;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_TEST   = 1'b1;

	localparam int QDEPTH = 4;

	localparam logic [31:0] MUR_C1 = 32'hcc9e2d51;
	localparam logic [31:0] MUR_C2 = 32'h1b873593;
	localparam logic [31:0] MUR_C3 = 32'h85ebca6b;
	localparam logic [31:0] MUR_C4 = 32'hc2b2ae35;
	localparam logic [31:0] MUR_E  = 32'he6546b64;

	typedef struct packed {
		logic op;
		logic skip;
		logic last;
	} bfk_flags_t;

	typedef struct packed {
		logic full;
		logic empty;
	} bfk_qstat_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic logic [31:0] mix5(input logic [31:0] x);
		return x + (x << 2) + MUR_E;
	endfunction

endpackage

// ===== design/bloom_filter_int64_keys_core.sv =====
// Bloom filter over 64-bit keys, MurmurHash3 x86 32-bit with seeds 0..k-1.
// Command channel: opcode/key transfer when start is high and busy is low.
// Result channel: done pulses for one cycle with present and inserted_total;
// the receiver cannot stall, so results are never held back.
// Config: cfg_we with cfg_index (0 filter_bits, 1 hash count) and cfg_data,
// which the user must write only while idle; the block does not enforce it.
// Other indexes are ignored. The front computes hashes with one shared 32x32
// multiplier and reduces each modulo filter_bits with a 4-bit-per-cycle
// remainder unit, after key setup in PK1A, PK1B, PK2A and PK2B. A 4-entry
// queue feeds the back, which does a read-modify-write of one 32-bit store
// word per position through its idle, read and update states. Busy drops
// once the front has queued every position, so the next command overlaps
// the back draining the previous one. After reset the store is cleared one
// word a cycle, all (MAX_FILTER_BITS+31)/32 words (2048 by default), with
// busy high; the count and registers reset.
module bloom_filter_int64_keys_core #(
	parameter int MAX_FILTER_BITS = bfk_pkg::DEF_MAX_FILTER_BITS,
	parameter int MAX_HASHES      = bfk_pkg::DEF_MAX_HASHES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           opcode,
	input  logic [63:0]                    key,
	output logic                           done,
	output logic                           present,
	output logic [31:0]                    inserted_total,
	input  logic                           cfg_we,
	input  logic [bfk_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bfk_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bfk_pkg::*;

	localparam int PW = $clog2(MAX_FILTER_BITS);
	localparam int EW = $bits(bfk_flags_t) + PW;

	logic [FILTER_BITS_W-1:0] filter_bits_q;
	logic [NUM_HASHES_W-1:0]  hash_count_q;

	logic          front_busy;
	logic          clearing;
	logic          accept;
	logic          push;
	bfk_flags_t    push_flags;
	logic [PW-1:0] push_pos;
	logic          pop;
	logic [EW-1:0] q_head;
	bfk_qstat_t    qstat;
	bfk_flags_t    head_flags;
	logic [PW-1:0] head_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_bits_q <= FILTER_BITS_W'(65536);
			hash_count_q  <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_FILTER_BITS)
				filter_bits_q <= cfg_data;
			else if (cfg_index == REG_NUM_HASHES)
				hash_count_q <= cfg_data[NUM_HASHES_W-1:0];
		end
	end

	assign busy   = front_busy || clearing;
	assign accept = start && !busy;

	assign head_flags = bfk_flags_t'(q_head[EW-1:PW]);
	assign head_pos   = q_head[PW-1:0];

	bfk_front #(
		.MAX_FILTER_BITS(MAX_FILTER_BITS),
		.MAX_HASHES     (MAX_HASHES),
		.PW             (PW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.opcode     (opcode),
		.key        (key),
		.filter_bits(filter_bits_q),
		.hash_count (hash_count_q),
		.qstat      (qstat),
		.front_busy (front_busy),
		.push       (push),
		.push_flags (push_flags),
		.push_pos   (push_pos)
	);

	bfk_queue #(
		.W(EW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_flags, push_pos}),
		.pop      (pop),
		.head     (q_head),
		.qstat    (qstat)
	);

	bfk_back #(
		.MAX_FILTER_BITS(MAX_FILTER_BITS),
		.PW             (PW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.qstat         (qstat),
		.head_flags    (head_flags),
		.head_pos      (head_pos),
		.pop           (pop),
		.clearing      (clearing),
		.done          (done),
		.present       (present),
		.inserted_total(inserted_total)
	);

endmodule

// ===== design/bfk_front.sv =====
`include "bloom_filter_int64_keys_core_macros.svh"

module bfk_front #(
	parameter int MAX_FILTER_BITS = 65536,
	parameter int MAX_HASHES      = 16,
	parameter int PW              = $clog2(MAX_FILTER_BITS)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic                              opcode,
	input  logic [63:0]                       key,
	input  logic [bfk_pkg::FILTER_BITS_W-1:0] filter_bits,
	input  logic [bfk_pkg::NUM_HASHES_W-1:0]  hash_count,
	input  bfk_pkg::bfk_qstat_t               qstat,
	output logic                              front_busy,
	output logic                              push,
	output bfk_pkg::bfk_flags_t               push_flags,
	output logic [PW-1:0]                     push_pos
);
	import bfk_pkg::*;

	localparam int MW = $clog2(MAX_FILTER_BITS + 1);
	localparam int SW = $clog2(MAX_HASHES + 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_PK1A = 4'd1;
	localparam logic [3:0] ST_PK1B = 4'd2;
	localparam logic [3:0] ST_PK2A = 4'd3;
	localparam logic [3:0] ST_PK2B = 4'd4;
	localparam logic [3:0] ST_H1   = 4'd5;
	localparam logic [3:0] ST_H2   = 4'd6;
	localparam logic [3:0] ST_F1   = 4'd7;
	localparam logic [3:0] ST_F2   = 4'd8;
	localparam logic [3:0] ST_DIV  = 4'd9;
	localparam logic [3:0] ST_PUSH = 4'd10;

	logic [3:0]    st_q;
	logic [63:0]   key_q;
	logic          op_q;
	logic          skip_q;
	logic [MW-1:0] m_q;
	logic [SW-1:0] kh_q;
	logic [SW-1:0] seed_q;
	logic [31:0]   h_q;
	logic [31:0]   k1_q;
	logic [31:0]   k2_q;
	logic [31:0]   div_q;
	logic [MW-1:0] rem_q;
	logic [2:0]    dcnt_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] prod;
	logic [31:0] g;
	logic [31:0] fb32;
	logic [31:0] eff_m;
	logic [31:0] nh32;
	logic [31:0] eff_k;
	logic [MW:0] r;
	logic [MW-1:0] rem_n;
	logic        is_last;

	assign g = h_q ^ 32'd8;

	always_comb begin
		unique case (st_q)
			ST_PK1A: begin
				mul_a = key_q[31:0];
				mul_b = MUR_C1;
			end
			ST_PK1B: begin
				mul_a = rotl32(h_q, 15);
				mul_b = MUR_C2;
			end
			ST_PK2A: begin
				mul_a = key_q[63:32];
				mul_b = MUR_C1;
			end
			ST_PK2B: begin
				mul_a = rotl32(h_q, 15);
				mul_b = MUR_C2;
			end
			ST_F1: begin
				mul_a = g ^ (g >> 16);
				mul_b = MUR_C3;
			end
			ST_F2: begin
				mul_a = h_q ^ (h_q >> 13);
				mul_b = MUR_C4;
			end
			default: begin
				mul_a = h_q;
				mul_b = MUR_C3;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	assign fb32  = 32'(filter_bits);
	assign eff_m = (fb32 == 32'd0) ? 32'd1 :
		(fb32 > 32'(MAX_FILTER_BITS)) ? 32'(MAX_FILTER_BITS) : fb32;
	assign nh32  = 32'(hash_count);
	assign eff_k = (nh32 > 32'(MAX_HASHES)) ? 32'(MAX_HASHES) : nh32;

	// four restoring remainder steps per cycle
	always_comb begin
		r = {1'b0, rem_q};
		for (int j = 0; j < 4; j++) begin
			r = {r[MW-1:0], div_q[31-j]};
			if (r >= {1'b0, m_q})
				r = r - {1'b0, m_q};
		end
		rem_n = r[MW-1:0];
	end

	assign is_last = skip_q || (({1'b0, seed_q} + 1'b1) == {1'b0, kh_q});

	assign front_busy = (st_q != ST_IDLE);
	assign push       = (st_q == ST_PUSH) && !qstat.full;
	assign push_flags = '{op: op_q, skip: skip_q, last: is_last};
	assign push_pos   = rem_q[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			key_q  <= '0;
			op_q   <= 1'b0;
			skip_q <= 1'b0;
			m_q    <= '0;
			kh_q   <= '0;
			seed_q <= '0;
			h_q    <= '0;
			k1_q   <= '0;
			k2_q   <= '0;
			div_q  <= '0;
			rem_q  <= '0;
			dcnt_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						key_q  <= key;
						op_q   <= opcode;
						m_q    <= eff_m[MW-1:0];
						kh_q   <= eff_k[SW-1:0];
						seed_q <= '0;
						skip_q <= 1'b0;
						st_q   <= ST_PK1A;
					end
				end
				ST_PK1A: begin
					h_q  <= prod;
					st_q <= ST_PK1B;
				end
				ST_PK1B: begin
					k1_q <= prod;
					st_q <= ST_PK2A;
				end
				ST_PK2A: begin
					h_q  <= prod;
					st_q <= ST_PK2B;
				end
				ST_PK2B: begin
					k2_q <= prod;
					if (kh_q == '0) begin
						skip_q <= 1'b1;
						rem_q  <= '0;
						st_q   <= ST_PUSH;
					end else begin
						st_q <= ST_H1;
					end
				end
				ST_H1: begin
					h_q  <= mix5(rotl32(32'(seed_q) ^ k1_q, 13));
					st_q <= ST_H2;
				end
				ST_H2: begin
					h_q  <= mix5(rotl32(h_q ^ k2_q, 13));
					st_q <= ST_F1;
				end
				ST_F1: begin
					h_q  <= prod;
					st_q <= ST_F2;
				end
				ST_F2: begin
					div_q  <= prod ^ (prod >> 16);
					rem_q  <= '0;
					dcnt_q <= '0;
					st_q   <= ST_DIV;
				end
				ST_DIV: begin
					rem_q  <= rem_n;
					div_q  <= div_q << 4;
					dcnt_q <= dcnt_q + 3'd1;
					if (dcnt_q == 3'd7)
						st_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!qstat.full) begin
						if (is_last) begin
							st_q <= ST_IDLE;
						end else begin
							seed_q <= seed_q + 1'b1;
							st_q   <= ST_H1;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`BFK_ASSERT_IMP(a_rem_below_mod, clk, arst_n, st_q == ST_DIV, rem_q < m_q)

endmodule

// ===== design/bfk_queue.sv =====
`include "bloom_filter_int64_keys_core_macros.svh"

module bfk_queue #(
	parameter int W = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [W-1:0]        push_data,
	input  logic                pop,
	output logic [W-1:0]        head,
	output bfk_pkg::bfk_qstat_t qstat
);
	import bfk_pkg::*;

	localparam int QPW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);

	logic [W-1:0]   slots_q [QDEPTH];
	logic [QPW-1:0] wr_q;
	logic [QPW-1:0] rd_q;
	logic [QCW-1:0] cnt_q;

	assign head        = slots_q[rd_q];
	assign qstat.full  = (cnt_q == QCW'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	`BFK_ASSERT_IMP(a_no_push_full, clk, arst_n, push, !qstat.full)
	`BFK_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, !qstat.empty)

endmodule

// ===== design/bfk_back.sv =====
`include "bloom_filter_int64_keys_core_macros.svh"

module bfk_back #(
	parameter int MAX_FILTER_BITS = 65536,
	parameter int PW              = $clog2(MAX_FILTER_BITS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bfk_pkg::bfk_qstat_t qstat,
	input  bfk_pkg::bfk_flags_t head_flags,
	input  logic [PW-1:0]       head_pos,
	output logic                pop,
	output logic                clearing,
	output logic                done,
	output logic                present,
	output logic [31:0]         inserted_total
);
	import bfk_pkg::*;

	localparam int WORDS = (MAX_FILTER_BITS + 31) / 32;
	localparam int AW    = PW - 5;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_READ = 2'd1;
	localparam logic [1:0] B_UPD  = 2'd2;

	logic [31:0]   mem [WORDS];
	logic [1:0]    bst_q;
	logic          clr_q;
	logic [AW-1:0] clr_cnt_q;
	bfk_flags_t    ent_flags_q;
	logic [PW-1:0] ent_pos_q;
	logic [31:0]   rd_q;
	logic          pres_q;
	logic [31:0]   cnt_q;
	logic          done_q;
	logic          present_q;
	logic [31:0]   total_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic [31:0]   bit_mask;
	logic          bit_ok;
	logic          pres_n;
	logic          fin;
	logic          fin_op;
	logic          fin_pres;
	logic [31:0]   cnt_n;

	assign pop      = (bst_q == B_IDLE) && !qstat.empty && !clr_q;
	assign clearing = clr_q;

	assign bit_mask  = 32'd1 << ent_pos_q[4:0];
	assign bit_ok    = rd_q[ent_pos_q[4:0]];
	assign mem_we    = clr_q || (bst_q == B_UPD && ent_flags_q.op == OP_INSERT);
	assign mem_waddr = clr_q ? clr_cnt_q : ent_pos_q[PW-1:5];
	assign mem_wdata = clr_q ? 32'd0 : (rd_q | bit_mask);

	assign pres_n   = pres_q && ((ent_flags_q.op == OP_TEST) ? bit_ok : 1'b1);
	assign fin      = (pop && head_flags.skip) || (bst_q == B_UPD && ent_flags_q.last);
	assign fin_op   = (bst_q == B_IDLE) ? head_flags.op : ent_flags_q.op;
	assign fin_pres = (bst_q == B_IDLE) ? pres_q : pres_n;
	assign cnt_n    = (cnt_q == 32'hffffffff) ? cnt_q : cnt_q + 32'd1;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (bst_q == B_READ)
			rd_q <= mem[ent_pos_q[PW-1:5]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q       <= B_IDLE;
			clr_q       <= 1'b1;
			clr_cnt_q   <= '0;
			ent_flags_q <= '0;
			ent_pos_q   <= '0;
			pres_q      <= 1'b1;
			cnt_q       <= '0;
			done_q      <= 1'b0;
			present_q   <= 1'b0;
			total_q     <= '0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (32'(clr_cnt_q) == 32'(WORDS - 1))
					clr_q <= 1'b0;
			end
			unique case (bst_q)
				B_IDLE: begin
					if (pop) begin
						ent_flags_q <= head_flags;
						ent_pos_q   <= head_pos;
						if (!head_flags.skip)
							bst_q <= B_READ;
					end
				end
				B_READ: bst_q <= B_UPD;
				B_UPD: begin
					pres_q <= ent_flags_q.last ? 1'b1 : pres_n;
					bst_q  <= B_IDLE;
				end
				default: bst_q <= B_IDLE;
			endcase
			done_q <= fin;
			if (fin) begin
				if (fin_op == OP_INSERT) begin
					cnt_q     <= cnt_n;
					total_q   <= cnt_n;
					present_q <= 1'b0;
				end else begin
					total_q   <= cnt_q;
					present_q <= fin_pres;
				end
			end
		end
	end

	assign done           = done_q;
	assign present        = present_q;
	assign inserted_total = total_q;

	`BFK_ASSERT_NXT(a_no_result_in_clear, clk, arst_n, clr_q, !done_q)

endmodule
